// ----- design/chd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman decoder package
// Shared widths, request codes and the command record that travels from the
// front part to the back part of the decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int MAX_LENGTH   = 16;
    localparam int SYMBOL_COUNT = 256;

    localparam int CODE_W  = MAX_LENGTH;          // partial code
    localparam int FIRST_W = MAX_LENGTH + 1;      // running first code
    localparam int LEN_W   = $clog2(MAX_LENGTH + 1);
    localparam int LIDX_W  = $clog2(MAX_LENGTH);  // count table index
    localparam int COUNT_W = 9;                   // codes per length
    localparam int SYM_W   = 8;
    localparam int SIDX_W  = $clog2(SYMBOL_COUNT);
    localparam int IDX_W   = 8;                   // table_index field
    localparam int BITS_W  = 4;                   // valid_bits field
    localparam int CFG_W   = 5;

    // Request codes on the input stream.
    localparam logic [1:0] REQ_COUNT  = 2'd0;
    localparam logic [1:0] REQ_SYMBOL = 2'd1;
    localparam logic [1:0] REQ_DATA   = 2'd2;

    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_SYMBOL = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [IDX_W-1:0]    index;
        logic [COUNT_W-1:0]  value;
        logic [7:0]          data;
        logic [BITS_W-1:0]   nbits;   // already limited to 0..8
        logic                eos;
    } cmd_t;

    typedef struct packed {
        logic idle;        // back part waits for a command
        logic pend_valid;  // a decoded result is held back for its last flag
    } chd_status_t;

endpackage

// ----- design/chd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/chd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman decoder front part
// Accepts input items, drops those that do nothing, turns the rest into
// commands and queues them in a two-entry buffer for the back part.
// ----------------------------------------------------------------------------
module chd_front
    import chd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  table_index,
    input  logic [8:0]  table_value,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  valid_bits,
    input  logic        end_of_stream,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        new_cmd;
    logic        keep;
    logic        push;
    logic        pop;

    // Classification: unknown requests and count loads past the table are
    // dropped here, so the back part never sees them.
    always_comb
    begin
        new_cmd       = '0;
        new_cmd.index = table_index;
        new_cmd.value = table_value;
        new_cmd.data  = data_byte;
        new_cmd.eos   = end_of_stream;
        new_cmd.nbits = (valid_bits > BITS_W'(8)) ? BITS_W'(8) : valid_bits;
        keep          = 1'b0;
        unique case (req_type)
            REQ_COUNT:
            begin
                new_cmd.kind = CMD_COUNT;
                keep = ({1'b0, table_index} < 9'(MAX_LENGTH));
            end
            REQ_SYMBOL:
            begin
                new_cmd.kind = CMD_SYMBOL;
                keep = ({1'b0, table_index} < 9'(SYMBOL_COUNT));
            end
            REQ_DATA:
            begin
                new_cmd.kind = CMD_DATA;
                keep = 1'b1;
            end
            default:
            begin
                new_cmd.kind = CMD_DATA;
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- design/chd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman decoder back part
// Executes queued commands: table loads, and bit-serial decoding of data
// bytes with a symbol table lookup and a held-back result for the last flag.
// ----------------------------------------------------------------------------
module chd_back
    import chd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SYM_W-1:0]  out_symbol,
    output logic              out_error,
    output logic              out_last,
    output chd_status_t       status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BIT   = 4'b0010,
        S_LOOK  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    maxlen_reg, maxlen_next;
    logic [COUNT_W-1:0]  counts_reg [MAX_LENGTH];
    logic [7:0]          byte_reg, byte_next;
    logic [BITS_W-1:0]   left_reg, left_next;
    logic                eos_reg, eos_next;
    logic [CODE_W-1:0]   partial_reg, partial_next;
    logic [LEN_W-1:0]    plen_reg, plen_next;
    logic [FIRST_W-1:0]  first_reg, first_next;
    logic [COUNT_W-1:0]  base_reg, base_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                pend_err_reg, pend_err_next;
    logic                out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]    out_sym_reg, out_sym_next;
    logic                out_err_reg, out_err_next;
    logic                out_last_reg, out_last_next;

    logic [CODE_W-1:0]   code_step;
    logic [LEN_W-1:0]    len_step;
    logic [COUNT_W-1:0]  count;
    logic [FIRST_W-1:0]  code_ext;
    logic [FIRST_W-1:0]  diff;
    logic [FIRST_W-1:0]  first_sum;
    logic                hit;
    logic                over;
    logic [LEN_W-1:0]    limit;
    logic [SIDX_W-1:0]   pos;
    logic [SYM_W-1:0]    ram_rdata;
    logic                ram_we;
    logic                ram_re;
    logic                out_free;
    logic                can_place;
    logic                new_valid;
    logic [SYM_W-1:0]    new_sym;
    logic                new_err;
    logic                flush_push;
    logic                clear;
    logic                count_we;

    // One decode step on the leading bit of the byte.
    always_comb
    begin
        code_step = {partial_reg[CODE_W-2:0], byte_reg[7]};
        len_step  = plen_reg + LEN_W'(1);
        count     = counts_reg[plen_reg[LIDX_W-1:0]];
        code_ext  = {1'b0, code_step};
        diff      = code_ext - first_reg;
        hit       = (code_ext >= first_reg) &&
                    (diff < {{(FIRST_W-COUNT_W){1'b0}}, count});
        pos       = base_reg[SIDX_W-1:0] + diff[SIDX_W-1:0];
        first_sum = first_reg + {{(FIRST_W-COUNT_W){1'b0}}, count};
        if (maxlen_reg == '0)
        begin
            limit = LEN_W'(1);
        end
        else if (maxlen_reg > CFG_W'(MAX_LENGTH))
        begin
            limit = LEN_W'(MAX_LENGTH);
        end
        else
        begin
            limit = LEN_W'(maxlen_reg);
        end
        over = (len_step >= limit);
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign can_place = !pend_valid_reg || out_free;
    assign cmd_ready = (state_reg == S_IDLE);
    assign count_we  = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == CMD_COUNT);
    assign ram_we    = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == CMD_SYMBOL);
    assign ram_re    = (state_reg == S_BIT) && hit;

    always_comb
    begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        left_next    = left_reg;
        eos_next     = eos_reg;
        partial_next = partial_reg;
        plen_next    = plen_reg;
        first_next   = first_reg;
        base_next    = base_reg;
        new_valid    = 1'b0;
        new_sym      = '0;
        new_err      = 1'b0;
        flush_push   = 1'b0;
        clear        = 1'b0;
        maxlen_next  = cfg_we ? cfg_wdata : maxlen_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_DATA))
                begin
                    byte_next  = cmd.data;
                    left_next  = cmd.nbits;
                    eos_next   = cmd.eos;
                    state_next = (cmd.nbits == '0) ? S_FLUSH : S_BIT;
                end
            end
            S_BIT:
            begin
                if (hit)
                begin
                    // Symbol found; its table entry is read this cycle.
                    clear      = 1'b1;
                    byte_next  = {byte_reg[6:0], 1'b0};
                    left_next  = left_reg - BITS_W'(1);
                    state_next = S_LOOK;
                end
                else if (over)
                begin
                    if (can_place)
                    begin
                        clear      = 1'b1;
                        new_valid  = 1'b1;
                        new_err    = 1'b1;
                        byte_next  = {byte_reg[6:0], 1'b0};
                        left_next  = left_reg - BITS_W'(1);
                        state_next = (left_reg == BITS_W'(1)) ? S_FLUSH : S_BIT;
                    end
                end
                else
                begin
                    partial_next = code_step;
                    plen_next    = len_step;
                    base_next    = base_reg + count;
                    first_next   = {first_sum[FIRST_W-2:0], 1'b0};
                    byte_next    = {byte_reg[6:0], 1'b0};
                    left_next    = left_reg - BITS_W'(1);
                    state_next   = (left_reg == BITS_W'(1)) ? S_FLUSH : S_BIT;
                end
            end
            S_LOOK:
            begin
                if (can_place)
                begin
                    new_valid  = 1'b1;
                    new_sym    = ram_rdata;
                    state_next = (left_reg == '0) ? S_FLUSH : S_BIT;
                end
            end
            S_FLUSH:
            begin
                if (can_place)
                begin
                    flush_push = pend_valid_reg;
                    clear      = eos_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (clear)
        begin
            partial_next = '0;
            plen_next    = '0;
            first_next   = '0;
            base_next    = '0;
        end
    end

    // Result staging: a new result waits in the pending register until the
    // next one, or the end of the byte, tells whether it is the last one.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sym_next    = out_sym_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;
        if (new_valid)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = pend_sym_reg;
                out_err_next   = pend_err_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = new_sym;
            pend_err_next   = new_err;
        end
        else if (flush_push)
        begin
            out_valid_next  = 1'b1;
            out_sym_next    = pend_sym_reg;
            out_err_next    = pend_err_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            maxlen_reg     <= CFG_W'(MAX_LENGTH);
            partial_reg    <= '0;
            plen_reg       <= '0;
            first_reg      <= '0;
            base_reg       <= '0;
            left_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_LENGTH; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            maxlen_reg     <= maxlen_next;
            partial_reg    <= partial_next;
            plen_reg       <= plen_next;
            first_reg      <= first_next;
            base_reg       <= base_next;
            left_reg       <= left_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (count_we)
            begin
                counts_reg[cmd.index[LIDX_W-1:0]] <= cmd.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        eos_reg      <= eos_next;
        pend_sym_reg <= pend_sym_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    chd_ram #(
        .WIDTH (SYM_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_symbol_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.index[SIDX_W-1:0]),
        .wdata (cmd.value[SYM_W-1:0]),
        .re    (ram_re),
        .raddr (pos),
        .rdata (ram_rdata)
    );

    assign out_valid         = out_valid_reg;
    assign out_symbol        = out_sym_reg;
    assign out_error         = out_err_reg;
    assign out_last          = out_last_reg;
    assign status.idle       = (state_reg == S_IDLE);
    assign status.pend_valid = pend_valid_reg;

endmodule

// ----- design/canonical_huffman_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Canonical Huffman decoder
// Loads a per-length code count table and a canonical symbol list, then
// decodes compressed bytes bit by bit into symbols or error results.
// ----------------------------------------------------------------------------
//
//  Channel   Ports            Direction  Contents
//  input     s_axis_*         in         tuser: req_type; tlast: end_of_stream;
//                                        tdata: table_index, table_value,
//                                        data_byte, valid_bits
//  output    m_axis_*         out        tdata: symbol; tuser: code_error;
//                                        tlast: last result of the item
//  config    cfg_we/cfg_wdata in         max_code_length, written at once
//
//  A load item is written into its table as the back part takes it.
//  A data item is taken in the idle state, then gets a decode step per valid
//  bit, a symbol RAM read per decoded symbol, and a closing flush step.
//  A two-entry queue takes new items while the back part works or stalls;
//  a full output register holds the back part until the result is taken.
//  Reset clears the count table, the partial code and all control state;
//  the symbol RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder
    import chd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: max_code_length.
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: table_index[7:0], table_value[8:0], data_byte[7:0],
    // valid_bits[3:0], three zero bits.
    input  logic [31:0] s_axis_tdata,
    // tuser: req_type[1:0].
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: symbol[7:0].
    output logic [7:0]  m_axis_tdata,
    // tuser: code_error.
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    logic        cmd_valid;
    logic        cmd_ready;
    cmd_t        cmd;
    chd_status_t status;

    // The front part classifies and queues items; the back part decodes.
    chd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_valid       (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .req_type      (s_axis_tuser),
        .table_index   (s_axis_tdata[7:0]),
        .table_value   (s_axis_tdata[16:8]),
        .data_byte     (s_axis_tdata[24:17]),
        .valid_bits    (s_axis_tdata[28:25]),
        .end_of_stream (s_axis_tlast),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    chd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_symbol (m_axis_tdata),
        .out_error  (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .status     (status)
    );

    // An error result never carries a symbol.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
        else $error("error result with a nonzero symbol");

    // Between items no result is held back waiting for its last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.idle |-> !status.pend_valid)
        else $error("pending result left over after an item");

    // The input side only stalls when commands are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> cmd_valid)
        else $error("input stalled with an empty command queue");

    // After a command is taken, the back part is busy or holds no pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !status.idle || !status.pend_valid)
        else $error("command taken while a result was pending");

endmodule
